/* hdl/fpc_pkg.sv */
// Shared constants for the fixed polyomino counter.
// No dependencies; used by fixed_polyomino_counter.
package fpc_pkg;

  localparam int CFG_W       = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int COUNT_W     = 32;
  localparam int MARK_W      = 8;
  // wide enough for any grid coordinate at the largest supported cell count
  localparam int COORD_W     = 8;

  localparam logic [MARK_W-1:0]  MARK_BLOCKED = 8'hFF;
  localparam logic [MARK_W-1:0]  MARK_FREE    = 8'h00;
  localparam logic [MARK_W-1:0]  MARK_ROOT    = 8'h01;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [CFG_W-1:0]   CELLS_RESET  = 5'd11;
  localparam logic [CFG_W-1:0]   CELLS_MIN    = 5'd2;

endpackage

/* hdl/fixed_polyomino_counter.sv */
// Fixed polyomino counter: Redelmeier untried-set search over RAM-held state.
// Depends on fpc_pkg and fpc_ram.
//
// A transfer with start_req = 1 counts all fixed polyominoes of cell_count
// cells (clamped to 2..MAX_CELLS) and returns the total, saturating at
// 2^32-1; a transfer with start_req = 0 returns the last total.
// A run first sweeps all MAX_CELLS*(2*MAX_CELLS-2) mark RAM entries (480 at
// the default), then walks the search tree: each inner node reads the marks
// of its in-grid neighbours and marks the free ones to grow, and clears them
// again to backtrack, all through the single-port-per-side mark RAM; the last
// level is counted in one step per parent. Only one run is in flight; the
// next transfer is taken once the result slot is free.
module fixed_polyomino_counter #(
  parameter int MAX_CELLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] start_req, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] fixed_count, [32] saturated, [39:33] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int GRID = MAX_CELLS * (2 * MAX_CELLS - 2);
  localparam int AW   = $clog2(GRID);
  localparam int LD   = 8 * MAX_CELLS;
  localparam int LAW  = $clog2(LD);
  localparam int LW   = $clog2(LD + 1);
  localparam int FAW  = $clog2(MAX_CELLS);
  localparam int NW   = $clog2(MAX_CELLS + 1);
  localparam int XW   = $clog2(2 * MAX_CELLS - 2);
  localparam int WW   = $clog2(2 * MAX_CELLS - 1);
  localparam int YW   = $clog2(MAX_CELLS);
  localparam int EW   = YW + XW + AW;
  localparam int FW   = 2 * LW + EW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_LOOP  = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_NRD   = 4'd4;
  localparam logic [3:0] S_NWR   = 4'd5;
  localparam logic [3:0] S_DESC  = 4'd6;
  localparam logic [3:0] S_POP   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  typedef struct packed {
    logic [YW-1:0] y;
    logic [XW-1:0] x;
    logic [AW-1:0] a;
  } cell_t;

  typedef struct packed {
    logic [LW-1:0] saved;
    logic [LW-1:0] idx;
    cell_t         node;
  } frame_t;

  logic [3:0]                  state_r, state_nxt;
  logic [fpc_pkg::CFG_W-1:0]   cc_r, cc_nxt;
  logic [NW-1:0]               n_r, n_nxt;
  logic [WW-1:0]               w_r, w_nxt;
  logic [fpc_pkg::COUNT_W-1:0] total_r, total_nxt;
  logic [FAW-1:0]              depth_r, depth_nxt;
  logic [LW-1:0]               saved_r, saved_nxt;
  logic [LW-1:0]               idx_r, idx_nxt;
  logic [LW-1:0]               grown_r, grown_nxt;
  cell_t                       cell_r, cell_nxt;
  logic [1:0]                  nb_r, nb_nxt;
  logic                        clr_r, clr_nxt;
  logic [AW-1:0]               iidx_r, iidx_nxt;
  logic [XW-1:0]               ix_r, ix_nxt;
  logic [NW-1:0]               iy_r, iy_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [fpc_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                      mk_we;
  logic [AW-1:0]             mk_waddr, mk_raddr;
  logic [fpc_pkg::MARK_W-1:0] mk_wdata, mk_rdata;
  logic                      ls_we;
  logic [LAW-1:0]            ls_waddr, ls_raddr;
  cell_t                     ls_wdata, ls_rdata;
  logic                      fr_we;
  logic [FAW-1:0]            fr_waddr, fr_raddr;
  frame_t                    fr_wdata, fr_rdata;

  fpc_ram #(.W(fpc_pkg::MARK_W), .D(GRID)) u_marks (
    .clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
    .raddr(mk_raddr), .rdata(mk_rdata));

  fpc_ram #(.W(EW), .D(LD)) u_list (
    .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
    .raddr(ls_raddr), .rdata(ls_rdata));

  fpc_ram #(.W(FW), .D(MAX_CELLS)) u_frames (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata));

  // neighbour of the current cell: left, down, right, up
  logic  nb_ok;
  cell_t nb_e;
  logic [fpc_pkg::COORD_W-1:0] cx, cy, cw, cn;

  always_comb begin
    cx    = fpc_pkg::COORD_W'(cell_r.x);
    cy    = fpc_pkg::COORD_W'(cell_r.y);
    cw    = fpc_pkg::COORD_W'(w_r);
    cn    = fpc_pkg::COORD_W'(n_r);
    nb_e  = cell_r;
    nb_ok = 1'b0;
    case (nb_r)
      2'd0: begin
        nb_ok  = (cx != '0);
        nb_e.x = cell_r.x - 1'b1;
        nb_e.a = cell_r.a - 1'b1;
      end
      2'd1: begin
        nb_ok  = (cy + 1'b1 < cn);
        nb_e.y = cell_r.y + 1'b1;
        nb_e.a = cell_r.a + AW'(w_r);
      end
      2'd2: begin
        nb_ok  = (cx + 1'b1 < cw);
        nb_e.x = cell_r.x + 1'b1;
        nb_e.a = cell_r.a + 1'b1;
      end
      default: begin
        nb_ok  = (cy != '0);
        nb_e.y = cell_r.y - 1'b1;
        nb_e.a = cell_r.a - AW'(w_r);
      end
    endcase
  end

  // set-up value of the mark at the sweep position
  logic [fpc_pkg::COORD_W-1:0] sx, sy;
  logic [fpc_pkg::MARK_W-1:0]  init_mark;

  always_comb begin
    sx = fpc_pkg::COORD_W'(ix_r);
    sy = fpc_pkg::COORD_W'(iy_r);
    if (sy >= cn) begin
      init_mark = fpc_pkg::MARK_FREE;
    end else if (sy == '0 && sx == cn - 2'd2) begin
      init_mark = fpc_pkg::MARK_ROOT;
    end else if ((sy + sx > cw) || (sx + 1'b1 < sy) || (sy == '0 && sx < cn - 2'd2)) begin
      init_mark = fpc_pkg::MARK_BLOCKED;
    end else begin
      init_mark = fpc_pkg::MARK_FREE;
    end
  end

  logic                        in_fire;
  logic [NW-1:0]               n_clamp;
  logic [fpc_pkg::COUNT_W:0]   sum_leaf;
  logic                        last_nb;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign last_nb    = (nb_r == 2'd3);

  always_comb begin
    if (cc_r < fpc_pkg::CELLS_MIN) begin
      n_clamp = NW'(2);
    end else if (int'(cc_r) > MAX_CELLS) begin
      n_clamp = NW'(MAX_CELLS);
    end else begin
      n_clamp = NW'(cc_r);
    end
    sum_leaf = {1'b0, total_r} + (fpc_pkg::COUNT_W + 1)'(saved_r - idx_r);
  end

  always_comb begin
    state_nxt     = state_r;
    cc_nxt        = cc_r;
    n_nxt         = n_r;
    w_nxt         = w_r;
    total_nxt     = total_r;
    depth_nxt     = depth_r;
    saved_nxt     = saved_r;
    idx_nxt       = idx_r;
    grown_nxt     = grown_r;
    cell_nxt      = cell_r;
    nb_nxt        = nb_r;
    clr_nxt       = clr_r;
    iidx_nxt      = iidx_r;
    ix_nxt        = ix_r;
    iy_nxt        = iy_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mk_we    = 1'b0;
    mk_waddr = nb_e.a;
    mk_wdata = fpc_pkg::MARK_FREE;
    mk_raddr = nb_e.a;
    ls_we    = 1'b0;
    ls_waddr = grown_r[LAW-1:0];
    ls_wdata = nb_e;
    ls_raddr = idx_r[LAW-1:0];
    fr_we    = 1'b0;
    fr_waddr = depth_r;
    fr_wdata = '{saved: saved_r, idx: idx_r, node: ls_rdata};
    fr_raddr = depth_r - 1'b1;

    if (cfg_valid && cfg_ready) begin
      cc_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tdata[0]) begin
            n_nxt     = n_clamp;
            w_nxt     = WW'({n_clamp, 1'b0} - 2'd2);
            total_nxt = '0;
            iidx_nxt  = '0;
            ix_nxt    = '0;
            iy_nxt    = '0;
            ls_we     = 1'b1;
            ls_waddr  = '0;
            ls_wdata  = '{y: '0, x: XW'(n_clamp - 2'd2), a: AW'(n_clamp - 2'd2)};
            state_nxt = S_INIT;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = fpc_pkg::OUT_TDATA_W'({total_r == fpc_pkg::COUNT_MAX, total_r});
          end
        end
      end
      S_INIT: begin
        mk_we    = 1'b1;
        mk_waddr = iidx_r;
        mk_wdata = init_mark;
        iidx_nxt = iidx_r + 1'b1;
        if (WW'(ix_r) == w_r - 1'b1) begin
          ix_nxt = '0;
          if (iy_r != n_r) begin
            iy_nxt = iy_r + 1'b1;
          end
        end else begin
          ix_nxt = ix_r + 1'b1;
        end
        if (iidx_r == AW'(GRID - 1)) begin
          depth_nxt = '0;
          saved_nxt = LW'(1);
          idx_nxt   = '0;
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (idx_r >= saved_r) begin
          if (depth_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_POP;
          end
        end else if (total_r == fpc_pkg::COUNT_MAX) begin
          state_nxt = S_DONE;
        end else if (NW'(depth_r) == n_r - 1'b1) begin
          total_nxt = sum_leaf[fpc_pkg::COUNT_W] ? fpc_pkg::COUNT_MAX
                                                 : sum_leaf[fpc_pkg::COUNT_W-1:0];
          idx_nxt   = saved_r;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        fr_we     = 1'b1;
        cell_nxt  = ls_rdata;
        grown_nxt = saved_r;
        nb_nxt    = '0;
        clr_nxt   = 1'b0;
        state_nxt = S_NRD;
      end
      S_NRD: begin
        if (nb_ok) begin
          state_nxt = S_NWR;
        end else if (last_nb) begin
          if (clr_r) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_LOOP;
          end else begin
            state_nxt = S_DESC;
          end
        end else begin
          nb_nxt = nb_r + 1'b1;
        end
      end
      S_NWR: begin
        if (clr_r) begin
          if (mk_rdata != fpc_pkg::MARK_BLOCKED && mk_rdata > fpc_pkg::MARK_W'(saved_r)) begin
            mk_we = 1'b1;
          end
        end else if (mk_rdata == fpc_pkg::MARK_FREE && grown_r < LW'(LD)) begin
          ls_we     = 1'b1;
          mk_we     = 1'b1;
          mk_wdata  = fpc_pkg::MARK_W'(grown_r) + 1'b1;
          grown_nxt = grown_r + 1'b1;
        end
        if (last_nb) begin
          if (clr_r) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_LOOP;
          end else begin
            state_nxt = S_DESC;
          end
        end else begin
          nb_nxt    = nb_r + 1'b1;
          state_nxt = S_NRD;
        end
      end
      S_DESC: begin
        depth_nxt = depth_r + 1'b1;
        saved_nxt = grown_r;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_LOOP;
      end
      S_POP: begin
        depth_nxt = depth_r - 1'b1;
        saved_nxt = fr_rdata.saved;
        idx_nxt   = fr_rdata.idx;
        cell_nxt  = fr_rdata.node;
        nb_nxt    = '0;
        clr_nxt   = 1'b1;
        state_nxt = S_NRD;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = fpc_pkg::OUT_TDATA_W'({total_r == fpc_pkg::COUNT_MAX, total_r});
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cc_r        <= fpc_pkg::CELLS_RESET;
      total_r     <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cc_r        <= cc_nxt;
      total_r     <= total_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    w_r        <= w_nxt;
    saved_r    <= saved_nxt;
    idx_r      <= idx_nxt;
    grown_r    <= grown_nxt;
    cell_r     <= cell_nxt;
    nb_r       <= nb_nxt;
    clr_r      <= clr_nxt;
    iidx_r     <= iidx_nxt;
    ix_r       <= ix_nxt;
    iy_r       <= iy_nxt;
    out_data_r <= out_data_nxt;
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOP) |-> (NW'(depth_r) < n_r))
    else $error("search depth beyond cell count");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NWR) |-> (grown_r <= LW'(LD) && saved_r <= grown_r))
    else $error("untried list length out of range");

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[fpc_pkg::COUNT_W] ==
                     (out_data_r[fpc_pkg::COUNT_W-1:0] == fpc_pkg::COUNT_MAX)))
    else $error("saturated flag does not match count");

  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !out_valid_r)
    else $error("result slot busy at end of run");

endmodule

/* hdl/fpc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* verif/fixed_polyomino_counter_test.sv */
`timescale 1ns / 1ps
// Testbench for fixed_polyomino_counter: stream stimulus, cell_count writes and a
// scoreboard that counts fixed polyominoes with its own untried-set search.
// Depends on fpc_pkg and the fixed_polyomino_counter RTL.

class polyomino_scoreboard;
  bit [4:0]  cells;
  bit [31:0] last_total;
  bit [32:0] pending[$];
  int        failures;
  int        results_seen;
  int        runs_seen;

  function new();
    cells = fpc_pkg::CELLS_RESET;
  endfunction

  function automatic bit [31:0] count_fixed(int n);
    localparam int MAXC = 16;
    localparam int GRID = MAXC * (2 * MAXC - 2);
    localparam int LDEPTH = 8 * MAXC;
    bit [7:0]  marks[GRID];
    int        untried[LDEPTH];
    int        chosen[MAXC];
    int        lvl_len[MAXC + 1];
    int        lvl_idx[MAXC + 1];
    int        w, d, cur, nlen, x, y, k, pos;
    bit [31:0] total;
    w = 2 * n - 2;
    foreach (marks[i]) marks[i] = fpc_pkg::MARK_FREE;
    for (y = 0; y < n; y++)
      for (x = 0; x < w; x++)
        if ((y + x > w) || (x + 1 < y) || (y == 0 && x < n - 2))
          marks[y * w + x] = fpc_pkg::MARK_BLOCKED;
    marks[n - 2] = fpc_pkg::MARK_ROOT;
    untried[0] = n - 2;
    total = 0;
    d = 0;
    lvl_len[0] = 1;
    lvl_idx[0] = 0;
    while (1) begin
      if (lvl_idx[d] >= lvl_len[d] || lvl_idx[d] >= LDEPTH || total == fpc_pkg::COUNT_MAX) begin
        if (d == 0) break;
        d--;
        cur = chosen[d];
      end else begin
        cur = untried[lvl_idx[d]];
        chosen[d] = cur;
        nlen = lvl_len[d];
        x = cur % w;
        y = cur / w;
        for (k = 0; k < 4; k++) begin
          pos = -1;
          case (k)
            0: if (x > 0) pos = cur - 1;
            1: if (y + 1 < n) pos = cur + w;
            2: if (x + 1 < w) pos = cur + 1;
            3: if (y > 0) pos = cur - w;
          endcase
          if (pos >= 0 && pos < GRID && marks[pos] == 0 && nlen < LDEPTH) begin
            untried[nlen] = pos;
            nlen++;
            marks[pos] = nlen[7:0];
          end
        end
        if (d + 1 >= n) begin
          if (total != fpc_pkg::COUNT_MAX) total++;
        end else begin
          lvl_len[d + 1] = nlen;
          lvl_idx[d + 1] = lvl_idx[d] + 1;
          d++;
          continue;
        end
      end
      // backtrack over cell at level d
      x = cur % w;
      y = cur / w;
      for (k = 0; k < 4; k++) begin
        pos = -1;
        case (k)
          0: if (x > 0) pos = cur - 1;
          1: if (y + 1 < n) pos = cur + w;
          2: if (x + 1 < w) pos = cur + 1;
          3: if (y > 0) pos = cur - w;
        endcase
        if (pos >= 0 && pos < GRID && marks[pos] != fpc_pkg::MARK_BLOCKED
            && marks[pos] > lvl_len[d])
          marks[pos] = fpc_pkg::MARK_FREE;
      end
      lvl_idx[d]++;
    end
    return total;
  endfunction

  function void note_start(bit start_req);
    int n;
    if (start_req) begin
      n = (cells < fpc_pkg::CELLS_MIN) ? 2 : (cells > 16) ? 16 : int'(cells);
      last_total = count_fixed(n);
      runs_seen++;
    end
    pending.push_back({last_total == fpc_pkg::COUNT_MAX, last_total});
  endfunction

  function void check_result(bit [39:0] tdata);
    bit [32:0] exp_val;
    results_seen++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, tdata);
      failures++;
      return;
    end
    exp_val = pending.pop_front();
    if (tdata[31:0] !== exp_val[31:0]) begin
      $display("%0t: fixed_count expected %0d actual %0d", $time, exp_val[31:0], tdata[31:0]);
      failures++;
    end
    if (tdata[32] !== exp_val[32]) begin
      $display("%0t: saturated expected %0d actual %0d", $time, exp_val[32], tdata[32]);
      failures++;
    end
  endfunction
endclass

module fixed_polyomino_counter_test;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [0] start_req, [7:1] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;          // [31:0] fixed_count, [32] saturated, [39:33] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = 5'd0;

  polyomino_scoreboard sb = new();

  int  snd_idle = 0;
  int  rcv_idle = 0;
  bit  hold_kick = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_cnt = 0;
  bit  in_take = 1'b0;
  bit  cfg_take = 1'b0;
  int  quiet_cycles = 0;

  fixed_polyomino_counter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample handshakes mid-cycle; each transfer completes at the next rising edge
  always @(negedge clk) begin
    in_take  <= in_tvalid && in_tready;
    cfg_take <= cfg_valid && cfg_ready;
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (rst_n)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 1000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_cnt  <= 400;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send_item(bit start_req);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, start_req};
    @(posedge clk);
    while (!in_take) @(posedge clk);
    sb.note_start(start_req);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cells(bit [4:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_take) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.cells = v;
  endtask

  function automatic bit [4:0] pick_cells();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 5'd8;
    if (r < 15) return 5'($urandom_range(1));
    return 5'($urandom_range(7, 2));
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle result after reset, clamped low counts, sizes 2..8
    send_item(1'b0);
    write_cells(5'd0);
    send_item(1'b1);
    send_item(1'b0);
    write_cells(5'd1);
    send_item(1'b1);
    for (int n = 2; n <= 8; n++) begin
      write_cells(5'(n));
      send_item(1'b1);
      send_item(1'b0);
    end

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 6 : (ph == 1) ? 67 : 0;
      rcv_idle = (ph == 0) ? 67 : (ph == 1) ? 6 : 0;
      for (int i = 0; i < 27; i++) begin
        if (i % 9 == 0) write_cells(pick_cells());
        if (ph == 0 && i == 4) begin
          in_tvalid <= 1'b0;
          hold_kick <= ~hold_kick;
          @(posedge clk);
        end
        send_item($urandom_range(99) < 40);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("Ran %0d enumerations among %0d results, cell_count 0..8, three idle mixes.",
             sb.runs_seen, sb.results_seen);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
hdl/fpc_pkg.sv
hdl/fpc_ram.sv
hdl/fixed_polyomino_counter.sv
verif/fixed_polyomino_counter_test.sv
